// ----- rtl/ecnwca_pkg.sv -----
`timescale 1ns / 1ps
// Package for the ECN window congestion avoidance block.
// Holds register indexes, reset values, field widths and the window rounding function.
// No dependencies.
package ecnwca_pkg;

  localparam int unsigned CREDIT_W = 17;
  localparam int unsigned COUNT_W  = 18;
  localparam int unsigned FX_W     = 32;
  localparam int unsigned EDGE_W   = 32;
  localparam int unsigned STEP_W   = 8;
  localparam int unsigned INIT_W   = 16;
  localparam int unsigned OUT_TDATA_W = 56;

  localparam logic [15:0] FRAC_MASK = 16'hFFFF;
  localparam logic [15:0] HALF_FRAC = 16'h8000;

  localparam logic [STEP_W-1:0] STEP_RST = 8'd1;
  localparam logic [INIT_W-1:0] INIT_RST = 16'd16;

  typedef enum logic [0:0] {
    CFG_INCREASE_STEP  = 1'b0,
    CFG_INITIAL_CREDIT = 1'b1
  } cfg_idx_t;

  // Round a 16.16 window to whole PDUs, ties to even.
  function automatic logic [CREDIT_W-1:0] round_window(input logic [FX_W-1:0] fx);
    logic [15:0] frac;
    logic [15:0] whole;
    logic        up;
    frac  = fx[15:0] & FRAC_MASK;
    whole = fx[31:16];
    up    = (frac > HALF_FRAC) || ((frac == HALF_FRAC) && whole[0]);
    return {1'b0, whole} + {16'd0, up};
  endfunction

endpackage

// ----- rtl/ecn_window_congestion_avoidance.sv -----
`timescale 1ns / 1ps
// ECN window congestion avoidance: one request per received PDU, one result each.
// Registers: input, then result; the window update is a single pass of adds and compares.
// Throughput: one request per cycle while out_tready is high.
// Reset (synchronous, rst_n low): increase step 1, window and credit 16 PDUs, counters clear,
// both registers empty.
// Depends on ecnwca_pkg.
module ecn_window_congestion_avoidance (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [0:0]                         cfg_index,
  input  logic [ecnwca_pkg::INIT_W-1:0]      cfg_wdata,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ecnwca_pkg::EDGE_W-1:0]      in_tdata,   // [31:0] left_edge
  input  logic [0:0]                         in_tuser,   // [0] ecn_marked
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ecnwca_pkg::OUT_TDATA_W-1:0] out_tdata,  // [16:0] credit, [48:17] right_edge
  output logic [0:0]                         out_tuser   // [0] window_updated
);
  import ecnwca_pkg::*;

  // input register
  logic                  in_v_r, in_v_nxt;
  logic                  in_mark_r;
  logic [EDGE_W-1:0]     in_left_r;

  // window state
  logic [STEP_W-1:0]     inc_step_r;
  logic [CREDIT_W-1:0]   cur_win_r, cur_win_nxt;
  logic [CREDIT_W-1:0]   prev_win_r, prev_win_nxt;
  logic [COUNT_W-1:0]    rcv_cnt_r, rcv_cnt_nxt;
  logic [COUNT_W-1:0]    mrk_cnt_r, mrk_cnt_nxt;
  logic [FX_W-1:0]       win_fx_r, win_fx_nxt;

  // result register
  logic                  out_v_r, out_v_nxt;
  logic [CREDIT_W-1:0]   out_credit_r;
  logic [EDGE_W-1:0]     out_right_r;
  logic                  out_upd_r;

  logic                  adv;
  logic                  restart;
  logic [COUNT_W-1:0]    rcv_inc;
  logic [COUNT_W-1:0]    mrk_inc;
  logic [COUNT_W-1:0]    round_len;
  logic                  close;
  logic                  congested;
  logic [FX_W-1:0]       shrink_fx;
  logic [FX_W:0]         grow_sum;
  logic [FX_W-1:0]       grow_fx;

  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;
  assign restart   = cfg_we && (cfg_idx_t'(cfg_index) == CFG_INITIAL_CREDIT);

  assign rcv_inc   = rcv_cnt_r + COUNT_W'(1);
  // marks count only once the previous window's PDUs have passed
  assign mrk_inc   = (in_mark_r && (rcv_inc > {1'b0, prev_win_r})) ?
                     mrk_cnt_r + COUNT_W'(1) : mrk_cnt_r;
  assign round_len = {1'b0, cur_win_r} + {1'b0, prev_win_r};
  assign close     = (rcv_inc == round_len);
  assign congested = (mrk_inc > {2'b00, cur_win_r[CREDIT_W-1:1]});
  assign shrink_fx = win_fx_r - {3'b000, win_fx_r[FX_W-1:3]};
  assign grow_sum  = {1'b0, win_fx_r} + {9'd0, inc_step_r, 16'd0};
  // saturate on overflow
  assign grow_fx   = grow_sum[FX_W] ? {FX_W{1'b1}} : grow_sum[FX_W-1:0];

  always_comb begin
    cur_win_nxt  = cur_win_r;
    prev_win_nxt = prev_win_r;
    rcv_cnt_nxt  = rcv_cnt_r;
    mrk_cnt_nxt  = mrk_cnt_r;
    win_fx_nxt   = win_fx_r;
    if (restart) begin
      cur_win_nxt  = {1'b0, cfg_wdata};
      prev_win_nxt = '0;
      rcv_cnt_nxt  = '0;
      mrk_cnt_nxt  = '0;
      win_fx_nxt   = {cfg_wdata, 16'd0};
    end else if (adv) begin
      rcv_cnt_nxt = rcv_inc;
      mrk_cnt_nxt = mrk_inc;
      if (close) begin
        prev_win_nxt = cur_win_r;
        rcv_cnt_nxt  = '0;
        mrk_cnt_nxt  = '0;
        if (congested) begin
          // a window of one is never shrunk
          if (cur_win_r != CREDIT_W'(1)) begin
            win_fx_nxt  = shrink_fx;
            cur_win_nxt = round_window(shrink_fx);
          end
        end else begin
          win_fx_nxt  = grow_fx;
          cur_win_nxt = round_window(grow_fx);
        end
      end
    end
  end

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_tvalid && in_tready) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (adv) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      inc_step_r <= STEP_RST;
      cur_win_r  <= {1'b0, INIT_RST};
      prev_win_r <= '0;
      rcv_cnt_r  <= '0;
      mrk_cnt_r  <= '0;
      win_fx_r   <= {INIT_RST, 16'd0};
    end else begin
      in_v_r     <= in_v_nxt;
      out_v_r    <= out_v_nxt;
      cur_win_r  <= cur_win_nxt;
      prev_win_r <= prev_win_nxt;
      rcv_cnt_r  <= rcv_cnt_nxt;
      mrk_cnt_r  <= mrk_cnt_nxt;
      win_fx_r   <= win_fx_nxt;
      if (cfg_we && (cfg_idx_t'(cfg_index) == CFG_INCREASE_STEP)) begin
        inc_step_r <= cfg_wdata[STEP_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_mark_r <= in_tuser[0];
      in_left_r <= in_tdata;
    end
    if (adv) begin
      out_credit_r <= cur_win_nxt;
      out_right_r  <= {15'd0, cur_win_nxt} + in_left_r;
      out_upd_r    <= close;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_right_r, out_credit_r};
  assign out_tuser  = out_upd_r;

  // an empty input register always takes a request
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_v_r |-> in_tready)
    else $error("input register empty but not ready");

  // a request that leaves the input register lands in the result register
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_v_r)
    else $error("result lost on advance");

  // a closed round clears both counters
  a_close_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && close && !restart) |=> (rcv_cnt_r == '0) && (mrk_cnt_r == '0))
    else $error("counters not cleared at round close");

  // writing the initial credit restarts the window
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> (cur_win_r == {1'b0, $past(cfg_wdata)}) &&
                (win_fx_r == {$past(cfg_wdata), 16'd0}) && (prev_win_r == '0))
    else $error("window not restarted after initial credit write");

endmodule
